// ===== rtl/lmst_pkg.sv =====
package lmst_pkg;

   // Table depth and derived widths
   localparam int MAX_LEN = 32;
   localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CNT_W   = $clog2(MAX_LEN + 1);

   // Fixed field widths
   localparam int VAL_W  = 32;
   localparam int MODE_W = 2;
   localparam int LEN_W  = 6;
   localparam int SLOT_W = 5;

   // Order mode codes
   localparam logic [MODE_W-1:0] MODE_STRICT_INC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WEAK_INC   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STRICT_DEC = 2'd2;
   localparam logic [MODE_W-1:0] MODE_WEAK_DEC   = 2'd3;

   typedef struct packed {
      logic signed [VAL_W-1:0] sample_value;
      logic                    end_of_sequence;
   } req_type;

   typedef struct packed {
      logic        [LEN_W-1:0]  run_length;
      logic        [SLOT_W-1:0] slot_index;
      logic signed [VAL_W-1:0]  tail_value;
      logic                     overflow_flag;
      logic                     last_of_run;
   } rsp_type;

   // Broadcast from the top level to every cell
   typedef struct packed {
      logic                    ins_en;
      logic [MODE_W-1:0]       order_mode;
      logic signed [VAL_W-1:0] value;
   } bcast_type;

   // Result buffer status
   typedef struct packed {
      logic can_push;
      logic full;
   } buf_stat_type;

endpackage

// ===== rtl/longest_monotone_subsequence_tails.sv =====
// Streaming patience-sort tails table for the longest monotone subsequence.
// Input channel req_ (valid/stall) carries one sample and an end mark per
// beat. Result channel rsp_ (valid/stall) returns result beats. csr_wr_en
// with csr_wr_data sets the order mode; write it only while idle.
// An ordinary sample is placed in its accept cycle by the row of cells: each
// cell compares the broadcast value with its tail and passes a found flag
// to its neighbor; its result is registered in the result queue. One
// sample per cycle is sustained while results are taken.
// An end-marked sample is placed in its accept cycle, then the tails are
// read out one beat per cycle while the result queue has room (run_length
// beats, ascending value order); no input is accepted during that readout,
// after which the table empties. Reset clears the tail count, the readout
// state, the result queue and sets the mode to strict increasing. A
// two-entry result queue lets one more sample in while the receiver stalls;
// once both entries hold, the input stalls until the receiver takes a beat.
module longest_monotone_subsequence_tails
   import lmst_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [MODE_W-1:0] csr_wr_data
);

   logic [MODE_W-1:0]       order_mode_ff, order_mode_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    rd_active_ff, rd_active_in;
   logic [IDX_W-1:0]        rd_k_ff, rd_k_in;
   logic                    rd_ovf_ff, rd_ovf_in;

   bcast_type               bcast;
   logic                    accept;
   logic [MAX_LEN-1:0]      occ;
   logic [MAX_LEN:0]        found;
   logic [MAX_LEN-1:0]      hit;
   logic signed [VAL_W-1:0] tails [MAX_LEN];
   logic [IDX_W-1:0]        slot;
   logic                    full;
   logic                    ovf;
   logic [CNT_W-1:0]        count_ins;
   logic [IDX_W-1:0]        rd_idx;
   logic                    rd_last;
   logic                    push;
   rsp_type                 push_data;
   buf_stat_type            stat;

   assign req_stall = rd_active_ff || stat.full;
   assign accept    = req_valid && !req_stall;

   assign bcast.ins_en     = accept;
   assign bcast.order_mode = order_mode_ff;
   assign bcast.value      = req_data.sample_value;

   // Row of cells with the found flag rippling from index 0 upward
   assign found[0] = 1'b0;
   for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
      localparam logic [CNT_W-1:0] CELL_POS = CNT_W'(i);
      assign occ[i] = CELL_POS < count_ff;
      lmst_cell u_cell (
         .clock         (clock),
         .bcast         (bcast),
         .occupied      (occ[i]),
         .prev_occupied ((i == 0) ? 1'b1 : occ[(i == 0) ? 0 : i-1]),
         .found_in      (found[i]),
         .found_out     (found[i+1]),
         .hit           (hit[i]),
         .tail          (tails[i])
      );
   end

   // Encode the written slot (at most one cell hits)
   always_comb begin
      slot = '0;
      for (int i = 0; i < MAX_LEN; i++) begin
         if (hit[i]) begin
            slot = slot | IDX_W'(i);
         end
      end
   end

   assign full      = count_ff == CNT_W'(MAX_LEN);
   assign ovf       = !found[MAX_LEN] && full;
   assign count_ins = (!found[MAX_LEN] && !full) ? count_ff + CNT_W'(1) : count_ff;

   // Readout address: upward for increasing modes, downward otherwise
   assign rd_idx  = order_mode_ff[1] ? IDX_W'(count_ff - CNT_W'(1) - CNT_W'(rd_k_ff))
                                     : rd_k_ff;
   assign rd_last = CNT_W'(rd_k_ff) == (count_ff - CNT_W'(1));

   // Result beat selection
   always_comb begin
      push      = 1'b0;
      push_data = '0;
      if (rd_active_ff) begin
         push                    = stat.can_push;
         push_data.run_length    = LEN_W'(count_ff);
         push_data.slot_index    = SLOT_W'(rd_idx);
         push_data.tail_value    = tails[rd_idx];
         push_data.overflow_flag = rd_ovf_ff;
         push_data.last_of_run   = rd_last;
      end else begin
         push                    = accept && !req_data.end_of_sequence;
         push_data.run_length    = LEN_W'(count_ins);
         push_data.slot_index    = SLOT_W'(slot);
         push_data.tail_value    = req_data.sample_value;
         push_data.overflow_flag = ovf;
         push_data.last_of_run   = 1'b1;
      end
   end

   // Count, readout sequencing and mode register
   always_comb begin
      order_mode_in = csr_wr_en ? csr_wr_data : order_mode_ff;
      count_in      = count_ff;
      rd_active_in  = rd_active_ff;
      rd_k_in       = rd_k_ff;
      rd_ovf_in     = rd_ovf_ff;
      if (rd_active_ff) begin
         if (stat.can_push) begin
            if (rd_last) begin
               rd_active_in = 1'b0;
               count_in     = '0;
            end else begin
               rd_k_in = rd_k_ff + IDX_W'(1);
            end
         end
      end else if (accept) begin
         count_in = count_ins;
         if (req_data.end_of_sequence) begin
            rd_active_in = 1'b1;
            rd_k_in      = '0;
            rd_ovf_in    = ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_mode_ff <= MODE_STRICT_INC;
         count_ff      <= '0;
         rd_active_ff  <= 1'b0;
      end else begin
         order_mode_ff <= order_mode_in;
         count_ff      <= count_in;
         rd_active_ff  <= rd_active_in;
      end
      rd_k_ff   <= rd_k_in;
      rd_ovf_ff <= rd_ovf_in;
   end

   lmst_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/lmst_cell.sv =====
module lmst_cell
   import lmst_pkg::*;
(
   input  logic                    clock,
   input  bcast_type               bcast,
   input  logic                    occupied,
   input  logic                    prev_occupied,
   input  logic                    found_in,
   output logic                    found_out,
   output logic                    hit,
   output logic signed [VAL_W-1:0] tail
);

   logic signed [VAL_W-1:0] tail_ff;
   logic signed [VAL_W-1:0] tail_in;
   logic                    take;
   logic                    first_empty;

   // Placement test against this cell's tail
   always_comb begin
      case (bcast.order_mode)
         MODE_STRICT_INC: take = occupied && (tail_ff >= bcast.value);
         MODE_WEAK_INC:   take = occupied && (tail_ff >  bcast.value);
         MODE_STRICT_DEC: take = occupied && (tail_ff <= bcast.value);
         MODE_WEAK_DEC:   take = occupied && (tail_ff <  bcast.value);
         default:         take = 1'b0;
      endcase
   end

   // First match wins; the first empty cell takes an append
   assign first_empty = !occupied && prev_occupied;
   assign found_out   = found_in || take;
   assign hit         = bcast.ins_en && !found_in && (take || first_empty);
   assign tail_in     = hit ? bcast.value : tail_ff;

   always_ff @(posedge clock) begin
      tail_ff <= tail_in;
   end

   assign tail = tail_ff;

endmodule

// ===== rtl/lmst_rsp_buf.sv =====
module lmst_rsp_buf
   import lmst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_type      push_data,
   output buf_stat_type stat,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   logic    head_vld_ff, head_vld_in;
   logic    skid_vld_ff, skid_vld_in;
   rsp_type head_ff, head_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign pop           = head_vld_ff && !rsp_stall;
   assign stat.can_push = !skid_vld_ff || pop;
   assign stat.full     = skid_vld_ff;

   // Two-entry queue: head drives the port, skid catches a stalled beat
   always_comb begin
      head_vld_in = head_vld_ff;
      skid_vld_in = skid_vld_ff;
      head_in     = head_ff;
      skid_in     = skid_ff;
      if (pop) begin
         if (skid_vld_ff) begin
            head_in = skid_ff;
            if (push) begin
               skid_in = push_data;
            end else begin
               skid_vld_in = 1'b0;
            end
         end else if (push) begin
            head_in = push_data;
         end else begin
            head_vld_in = 1'b0;
         end
      end else if (push) begin
         if (!head_vld_ff) begin
            head_in     = push_data;
            head_vld_in = 1'b1;
         end else begin
            skid_in     = push_data;
            skid_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         head_vld_ff <= head_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = head_vld_ff;
   assign rsp_data  = head_ff;

endmodule
